>>> src/reverse_tail_crystal_ball_eval_top_defines.svh
// Assertion macros shared by the crystal-ball evaluator RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef REVERSE_TAIL_CRYSTAL_BALL_EVAL_TOP_DEFINES_SVH
`define REVERSE_TAIL_CRYSTAL_BALL_EVAL_TOP_DEFINES_SVH
`ifndef SYNTH
`define RTCB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtcb: same-cycle check failed");
`define RTCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcb: next-cycle check failed");
`else
`define RTCB_ASSERT_NOW(label, ante, cons)
`define RTCB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/rtcb_pkg.sv
// Shared constants, types and constant functions of the crystal-ball evaluator.
// No dependencies.
package rtcb_pkg;

    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned X_W       = 32;
    localparam int unsigned OUT_W     = 40;
    localparam int unsigned TP_W      = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 40;

    localparam int unsigned DVD_W     = X_W + FRAC_BITS;   // divider dividend / quotient
    localparam int unsigned DVS_W     = 32;                // divider divisor
    localparam int unsigned LV_W      = 50;                // log2 operand
    localparam int unsigned LOG_W     = 7 + FRAC_BITS;     // signed log2 result
    localparam int unsigned LOG_LAT   = FRAC_BITS + 2;

    localparam logic [30:0] LOG2E_Q30 = 31'h5C551D95;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [31:0] CENTER_RST = 32'd11304960;
    localparam logic [39:0] PEAK_RST   = 40'd65536;
    localparam logic [31:0] WIDTH_RST  = 32'd65536;
    localparam logic [31:0] TSTART_RST = 32'hFFFF0000;
    localparam logic [23:0] TPOWER_RST = 24'd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER     = 3'd0,
        REG_PEAK       = 3'd1,
        REG_WIDTH      = 3'd2,
        REG_TAIL_START = 3'd3,
        REG_TAIL_POWER = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic gauss;
        logic fault;
        logic zero;
        logic tail_pow;
    } rtcb_side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bw;
        rem = v;
        res = '0;
        bw  = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bw) begin
                rem = rem - (res + bw);
                res = (res >> 1) + bw;
            end else begin
                res = res >> 1;
            end
            bw = bw >> 2;
        end
        return res;
    endfunction

    // Q30 value of 2^(2^-i)
    function automatic logic [31:0] root_q30(input int i);
        logic [63:0] root;
        root = 64'h8000_0000;
        for (int k = 1; k <= i; k++) begin
            root = isqrt64(root << 30);
        end
        return root[31:0];
    endfunction

endpackage

>>> src/rtcb_sample_if.sv
// Input channel carrying one sample position per transaction.
// Uses rtcb_pkg for the field width.
interface rtcb_sample_if;
    logic                      valid;
    logic                      ready;
    logic [rtcb_pkg::X_W-1:0]  sample_pos;
    modport source (output valid, output sample_pos, input ready);
    modport sink   (input valid, input sample_pos, output ready);
endinterface

>>> src/rtcb_result_if.sv
// Output channel carrying one curve value and fault flag per transaction.
// Uses rtcb_pkg for the field width.
interface rtcb_result_if;
    logic                       valid;
    logic                       ready;
    logic [rtcb_pkg::OUT_W-1:0] curve_value;
    logic                       math_fault;
    modport source (output valid, output curve_value, output math_fault, input ready);
    modport sink   (input valid, input curve_value, input math_fault, output ready);
endinterface

>>> src/rtcb_cfg_if.sv
// Configuration write channel: register index and write data.
// Uses rtcb_pkg for the widths.
interface rtcb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rtcb_pkg::CFG_IDX_W-1:0] index;
    logic [rtcb_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/rtcb_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses rtcb_pkg widths; the divisor must stay constant while items are in flight.
module rtcb_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rtcb_pkg::DVD_W-1:0] dividend,
    input  logic [rtcb_pkg::DVS_W-1:0] divisor,
    output logic [rtcb_pkg::DVD_W-1:0] quotient
);

    logic [rtcb_pkg::DVD_W-1:0] dq_reg  [rtcb_pkg::DVD_W];
    logic [rtcb_pkg::DVS_W-1:0] rem_reg [rtcb_pkg::DVD_W-1];

    genvar k;
    for (k = 0; k < rtcb_pkg::DVD_W; k++)
    begin : g_stage
        logic [rtcb_pkg::DVD_W-1:0] dq_in;
        logic [rtcb_pkg::DVS_W-1:0] rem_in;
        logic [rtcb_pkg::DVS_W:0]   trial;
        logic [rtcb_pkg::DVS_W:0]   diff;
        logic                       fits;

        if (k == 0)
        begin : g_first
            assign dq_in  = dividend;
            assign rem_in = '0;
        end
        else
        begin : g_rest
            assign dq_in  = dq_reg[k-1];
            assign rem_in = rem_reg[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign trial = {rem_in, dq_in[rtcb_pkg::DVD_W-1]};
        assign diff  = trial - {1'b0, divisor};
        assign fits  = (trial >= {1'b0, divisor});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[k] <= {dq_in[rtcb_pkg::DVD_W-2:0], fits};
            end
        end

        if (k < rtcb_pkg::DVD_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fits ? diff[rtcb_pkg::DVS_W-1:0]
                                       : trial[rtcb_pkg::DVS_W-1:0];
                end
            end
        end
    end

    assign quotient = dq_reg[rtcb_pkg::DVD_W-1];

endmodule

>>> src/rtcb_log2.sv
// Pipelined base-2 logarithm of a positive fixed-point value: leading-one search,
// normalize, then one mantissa squaring per stage. Uses rtcb_pkg.
module rtcb_log2 (
    input  logic                             clk,
    input  logic                             en,
    input  logic [rtcb_pkg::LV_W-1:0]        v,
    output logic signed [rtcb_pkg::LOG_W-1:0] log_val
);

    logic [rtcb_pkg::LV_W-1:0] v0_reg;
    logic [5:0]                p0_reg;
    logic [5:0]                p_next;
    logic [30:0]               m1_reg;
    logic [5:0]                p1_reg;
    logic [rtcb_pkg::LV_W+29:0] norm;

    logic [30:0]                   sq_m_reg [rtcb_pkg::FRAC_BITS];
    logic [rtcb_pkg::FRAC_BITS-1:0] sq_f_reg [rtcb_pkg::FRAC_BITS];
    logic [5:0]                    sq_p_reg [rtcb_pkg::FRAC_BITS];

    always_comb
    begin
        p_next = '0;
        for (int b = 0; b < rtcb_pkg::LV_W; b++)
        begin
            if (v[b])
            begin
                p_next = 6'(b);
            end
        end
    end

    // bring the leading one to bit 30
    assign norm = ({30'b0, v0_reg} << 30) >> p0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg <= v;
            p0_reg <= p_next;
            m1_reg <= norm[30:0];
            p1_reg <= p0_reg;
        end
    end

    genvar k;
    for (k = 0; k < rtcb_pkg::FRAC_BITS; k++)
    begin : g_sq
        logic [30:0]                   m_in;
        logic [rtcb_pkg::FRAC_BITS-1:0] f_in;
        logic [5:0]                    p_in;
        logic [61:0]                   sq;
        logic [31:0]                   m2;

        if (k == 0)
        begin : g_first
            assign m_in = m1_reg;
            assign f_in = '0;
            assign p_in = p1_reg;
        end
        else
        begin : g_rest
            assign m_in = sq_m_reg[k-1];
            assign f_in = sq_f_reg[k-1];
            assign p_in = sq_p_reg[k-1];
        end

        assign sq = m_in * m_in;
        assign m2 = sq[61:30];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_m_reg[k] <= m2[31] ? m2[31:1] : m2[30:0];
                sq_f_reg[k] <= {f_in[rtcb_pkg::FRAC_BITS-2:0], m2[31]};
                sq_p_reg[k] <= p_in;
            end
        end
    end

    assign log_val = {7'({1'b0, sq_p_reg[rtcb_pkg::FRAC_BITS-1]}) - 7'(rtcb_pkg::FRAC_BITS),
                      sq_f_reg[rtcb_pkg::FRAC_BITS-1]};

endmodule

>>> src/reverse_tail_crystal_ball_eval_top.sv
// Crystal-ball curve evaluator with the power-law tail on the high side. One sample
// position enters per clock and passes through 1 input stage, 48 divider stages (one
// quotient bit each), 5 stages for branch select and the squared-exponent term, 18 log2
// stages (normalize, then one mantissa squaring each), 3 stages for the tail exponent,
// 16 exp2 stages (one root multiply each), a scale multiply and the output register.
// The whole pipeline holds while a result waits to be taken.
// Configuration registers must only be written while no transaction is in flight.
`include "reverse_tail_crystal_ball_eval_top_defines.svh"

module reverse_tail_crystal_ball_eval_top (
    input  logic                  clk,
    input  logic                  rst_n,
    rtcb_sample_if.sink           sample_ch,
    rtcb_result_if.source         result_ch,
    rtcb_cfg_if.sink              cfg_ch
);

    localparam int unsigned DW = rtcb_pkg::DVD_W;
    localparam int unsigned LL = rtcb_pkg::LOG_LAT;
    localparam int unsigned FB = rtcb_pkg::FRAC_BITS;

    // configuration
    logic [31:0] center_reg;
    logic [39:0] peak_reg;
    logic [31:0] width_reg;
    logic [31:0] tstart_reg;
    logic [23:0] tpower_reg;

    logic [31:0] width_eff;
    logic [31:0] aabs;
    logic        en;

    // pipeline registers
    logic          p0_valid_reg;
    logic [DW-1:0] p0_dvd_reg;
    logic          p0_neg_reg;
    logic [DW-1:0] dvd_next;
    logic [32:0]   num;
    logic [32:0]   mag;

    logic [DW-1:0] div_valid_reg;
    logic          div_neg_reg [DW];
    logic [DW-1:0] quo_t;
    logic [DW-1:0] quo_r;

    logic               t_valid_reg;
    logic signed [48:0] t_reg;
    logic [40:0]        r_reg;

    logic                 b_valid_reg;
    logic [31:0]          b_q_reg;
    logic [49:0]          b_d_reg;
    logic [40:0]          b_r_reg;
    rtcb_pkg::rtcb_side_t b_side_reg;
    logic signed [49:0]   t_ext;
    logic signed [49:0]   malpha;
    logic [48:0]          tabs;
    logic signed [50:0]   d_full;
    logic                 gauss;
    rtcb_pkg::rtcb_side_t side_next;

    logic [2:0]           h_valid_reg;
    logic [63:0]          h1_sq_reg;
    logic [46:0]          h2_p1_reg;
    logic [60:0]          h2_p2_reg;
    logic [47:0]          h3_g_reg;
    logic [49:0]          h_d_reg    [3];
    logic [40:0]          h_r_reg    [3];
    rtcb_pkg::rtcb_side_t h_side_reg [3];

    logic [LL-1:0]        lg_valid_reg;
    logic [47:0]          lg_g_reg    [LL];
    rtcb_pkg::rtcb_side_t lg_side_reg [LL];
    logic signed [rtcb_pkg::LOG_W-1:0] log_r;
    logic signed [rtcb_pkg::LOG_W-1:0] log_d;

    logic                 df_valid_reg;
    logic signed [23:0]   df_diff_reg;
    logic [47:0]          df_g_reg;
    rtcb_pkg::rtcb_side_t df_side_reg;

    logic                 mu_valid_reg;
    logic signed [48:0]   mu_term_reg;
    logic [47:0]          mu_g_reg;
    rtcb_pkg::rtcb_side_t mu_side_reg;

    logic                 e_valid_reg;
    logic signed [49:0]   e_reg;
    rtcb_pkg::rtcb_side_t e_side_reg;
    logic signed [49:0]   e_next;

    logic [FB-1:0]        pw_valid_reg;
    logic [30:0]          pw_m_reg    [FB];
    logic [FB-1:0]        pw_f_reg    [FB];
    logic signed [33:0]   pw_ip_reg   [FB];
    rtcb_pkg::rtcb_side_t pw_side_reg [FB];

    logic                 pr_valid_reg;
    logic [60:0]          pr_prod_reg;
    logic signed [34:0]   pr_sh_reg;
    logic                 pr_kill_reg;
    logic                 pr_fault_reg;

    logic                 out_valid_reg;
    logic [39:0]          out_value_reg;
    logic                 out_fault_reg;
    logic [39:0]          value_next;

    // ------------------------------------------------------------------ config
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= rtcb_pkg::CENTER_RST;
            peak_reg   <= rtcb_pkg::PEAK_RST;
            width_reg  <= rtcb_pkg::WIDTH_RST;
            tstart_reg <= rtcb_pkg::TSTART_RST;
            tpower_reg <= rtcb_pkg::TPOWER_RST;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                rtcb_pkg::REG_CENTER:     center_reg <= cfg_ch.data[31:0];
                rtcb_pkg::REG_PEAK:       peak_reg   <= cfg_ch.data[39:0];
                rtcb_pkg::REG_WIDTH:      width_reg  <= cfg_ch.data[31:0];
                rtcb_pkg::REG_TAIL_START: tstart_reg <= cfg_ch.data[31:0];
                rtcb_pkg::REG_TAIL_POWER: tpower_reg <= cfg_ch.data[23:0];
                default: ;
            endcase
        end
    end

    assign width_eff = (width_reg == '0) ? 32'd1 : width_reg;
    assign aabs      = tstart_reg[31] ? (~tstart_reg + 32'd1) : tstart_reg;

    // advance everything unless a finished result is waiting
    assign en              = !out_valid_reg || result_ch.ready;
    assign sample_ch.ready = en;

    // ------------------------------------------------------------------ input
    assign num      = {1'b0, sample_ch.sample_pos} - {1'b0, center_reg};
    assign mag      = num[32] ? (~num + 33'd1) : num;
    assign dvd_next = {mag[31:0], FB'(0)};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_dvd_reg <= dvd_next;
            p0_neg_reg <= num[32];
        end
    end

    // ------------------------------------------------------------------ dividers
    rtcb_div u_div_t (
        .clk      (clk),
        .en       (en),
        .dividend (p0_dvd_reg),
        .divisor  (width_eff),
        .quotient (quo_t)
    );

    rtcb_div u_div_r (
        .clk      (clk),
        .en       (en),
        .dividend ({8'b0, tpower_reg, FB'(0)}),
        .divisor  (aabs),
        .quotient (quo_r)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_neg_reg[0] <= p0_neg_reg;
            for (int k = 1; k < DW; k++)
            begin
                div_neg_reg[k] <= div_neg_reg[k-1];
            end
            t_reg <= div_neg_reg[DW-1] ? -$signed({1'b0, quo_t}) : $signed({1'b0, quo_t});
            r_reg <= quo_r[40:0];
        end
    end

    // ------------------------------------------------------------------ branch
    assign t_ext  = {t_reg[48], t_reg};
    assign malpha = -$signed({{18{tstart_reg[31]}}, tstart_reg});
    assign gauss  = (t_ext <= malpha);
    assign tabs   = t_reg[48] ? 49'(-t_reg) : 49'(t_reg);
    assign d_full = $signed({10'b0, r_reg}) - $signed({19'b0, aabs}) + $signed({{2{t_reg[48]}}, t_reg});

    always_comb
    begin
        side_next.gauss    = gauss;
        side_next.fault    = !gauss && ((aabs == '0) || (d_full <= 0));
        side_next.zero     = !gauss && !side_next.fault && (tpower_reg != '0) && (r_reg == '0);
        side_next.tail_pow = !gauss && (tpower_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (gauss)
            begin
                b_q_reg <= (tabs > 49'h0_8000_0000) ? 32'h8000_0000 : tabs[31:0];
            end
            else
            begin
                b_q_reg <= aabs;
            end
            b_d_reg    <= d_full[49:0];
            b_r_reg    <= r_reg;
            b_side_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------ q^2/2 * log2(e)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_sq_reg <= b_q_reg * b_q_reg;
            h2_p1_reg <= h1_sq_reg[62:47] * rtcb_pkg::LOG2E_Q30;
            h2_p2_reg <= h1_sq_reg[46:17] * rtcb_pkg::LOG2E_Q30;
            h3_g_reg  <= {1'b0, h2_p1_reg} + {17'b0, h2_p2_reg[60:30]};
            h_d_reg[0]    <= b_d_reg;
            h_r_reg[0]    <= b_r_reg;
            h_side_reg[0] <= b_side_reg;
            for (int k = 1; k < 3; k++)
            begin
                h_d_reg[k]    <= h_d_reg[k-1];
                h_r_reg[k]    <= h_r_reg[k-1];
                h_side_reg[k] <= h_side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------ logs
    rtcb_log2 u_log_r (
        .clk     (clk),
        .en      (en),
        .v       ({9'b0, h_r_reg[2]}),
        .log_val (log_r)
    );

    rtcb_log2 u_log_d (
        .clk     (clk),
        .en      (en),
        .v       (h_d_reg[2]),
        .log_val (log_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_g_reg[0]    <= h3_g_reg;
            lg_side_reg[0] <= h_side_reg[2];
            for (int k = 1; k < LL; k++)
            begin
                lg_g_reg[k]    <= lg_g_reg[k-1];
                lg_side_reg[k] <= lg_side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------ exponent
    assign e_next = mu_side_reg.tail_pow
                  ? 50'(mu_term_reg >>> FB) - $signed({2'b0, mu_g_reg})
                  : -$signed({2'b0, mu_g_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            df_diff_reg <= 24'(log_r) - 24'(log_d);
            df_g_reg    <= lg_g_reg[LL-1];
            df_side_reg <= lg_side_reg[LL-1];
            mu_term_reg <= $signed({1'b0, tpower_reg}) * df_diff_reg;
            mu_g_reg    <= df_g_reg;
            mu_side_reg <= df_side_reg;
            e_reg       <= e_next;
            e_side_reg  <= mu_side_reg;
        end
    end

    // ------------------------------------------------------------------ exp2
    genvar s;
    for (s = 0; s < FB; s++)
    begin : g_pow
        localparam logic [31:0] ROOT = rtcb_pkg::root_q30(s + 1);
        logic [30:0]          m_in;
        logic [FB-1:0]        f_in;
        logic signed [33:0]   ip_in;
        rtcb_pkg::rtcb_side_t side_in;
        logic [62:0]          prod;

        if (s == 0)
        begin : g_first
            assign m_in    = 31'h4000_0000;
            assign f_in    = e_reg[FB-1:0];
            assign ip_in   = e_reg[49:FB];
            assign side_in = e_side_reg;
        end
        else
        begin : g_rest
            assign m_in    = pw_m_reg[s-1];
            assign f_in    = pw_f_reg[s-1];
            assign ip_in   = pw_ip_reg[s-1];
            assign side_in = pw_side_reg[s-1];
        end

        assign prod = m_in * ROOT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pw_m_reg[s]    <= f_in[FB-1-s] ? prod[60:30] : m_in;
                pw_f_reg[s]    <= f_in;
                pw_ip_reg[s]   <= ip_in;
                pw_side_reg[s] <= side_in;
            end
        end
    end

    // ------------------------------------------------------------------ scale and shift
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_prod_reg  <= peak_reg * pw_m_reg[FB-1][30:10];
            pr_sh_reg    <= 35'(pw_ip_reg[FB-1]) - 35'sd20;
            pr_kill_reg  <= pw_side_reg[FB-1].fault || pw_side_reg[FB-1].zero
                            || (peak_reg == '0);
            pr_fault_reg <= pw_side_reg[FB-1].fault;
        end
    end

    always_comb
    begin
        logic [100:0]       wide;
        logic [60:0]        sr;
        logic signed [34:0] nsh;
        wide = {40'b0, pr_prod_reg} << pr_sh_reg[5:0];
        nsh  = -pr_sh_reg;
        sr   = pr_prod_reg >> nsh[5:0];
        if (pr_kill_reg)
        begin
            value_next = '0;
        end
        else if (!pr_sh_reg[34])
        begin
            if (pr_sh_reg >= 35'sd40 || (|wide[100:40]))
            begin
                value_next = rtcb_pkg::OUT_MAX;
            end
            else
            begin
                value_next = wide[39:0];
            end
        end
        else if (nsh >= 35'sd63)
        begin
            value_next = '0;
        end
        else
        begin
            value_next = (|sr[60:40]) ? rtcb_pkg::OUT_MAX : sr[39:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg <= value_next;
            out_fault_reg <= pr_fault_reg;
        end
    end

    // ------------------------------------------------------------------ valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg  <= 1'b0;
            div_valid_reg <= '0;
            t_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            h_valid_reg   <= '0;
            lg_valid_reg  <= '0;
            df_valid_reg  <= 1'b0;
            mu_valid_reg  <= 1'b0;
            e_valid_reg   <= 1'b0;
            pw_valid_reg  <= '0;
            pr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_valid_reg  <= sample_ch.valid;
            div_valid_reg <= {div_valid_reg[DW-2:0], p0_valid_reg};
            t_valid_reg   <= div_valid_reg[DW-1];
            b_valid_reg   <= t_valid_reg;
            h_valid_reg   <= {h_valid_reg[1:0], b_valid_reg};
            lg_valid_reg  <= {lg_valid_reg[LL-2:0], h_valid_reg[2]};
            df_valid_reg  <= lg_valid_reg[LL-1];
            mu_valid_reg  <= df_valid_reg;
            e_valid_reg   <= mu_valid_reg;
            pw_valid_reg  <= {pw_valid_reg[FB-2:0], e_valid_reg};
            pr_valid_reg  <= pw_valid_reg[FB-1];
            out_valid_reg <= pr_valid_reg;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.curve_value = out_value_reg;
    assign result_ch.math_fault  = out_fault_reg;

    // ------------------------------------------------------------------ checks
    `RTCB_ASSERT_NOW(a_fault_gives_zero, out_valid_reg && out_fault_reg, out_value_reg == '0)
    `RTCB_ASSERT_NOW(a_gauss_clean, b_valid_reg && b_side_reg.gauss, !b_side_reg.fault && !b_side_reg.zero)
    `RTCB_ASSERT_NOW(a_zero_needs_r0, b_valid_reg && b_side_reg.zero, b_r_reg == '0)
    `RTCB_ASSERT_NEXT(a_stall_holds, !en, $stable(div_valid_reg) && $stable(pw_valid_reg))

endmodule
